// ===== sv/gfir_pkg.sv =====
// ============================================================================
// gfir_pkg
// Shared widths, codes and types for the structured-grid face resolver.
// ============================================================================
`default_nettype none

package gfir_pkg;

  // Field widths
  localparam int COORD_W  = 11;
  localparam int ROW_W    = 21;
  localparam int ID_W     = 32;
  localparam int CELL_W   = 30;
  localparam int PATCH_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [COORD_W-1:0] MAX_EXTENT = 11'd1024;

  // Normal axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 2'd3;

  // Multiply lanes: face id, owner cell, neighbour cell, partner face id
  localparam int N_LANES   = 4;
  localparam int LANE_FACE = 0;
  localparam int LANE_OWN  = 1;
  localparam int LANE_NB   = 2;
  localparam int LANE_PAIR = 3;

  // Lattice coordinate triple, index 0 is x
  typedef logic [2:0][COORD_W-1:0] coord_vec_t;

  // Stage load enables handed to each lane
  typedef struct packed {
    logic en_s2;
    logic en_s3;
  } lane_ctrl_t;

  // Per-word flags that ride along the pipeline
  typedef struct packed {
    logic               ok;
    logic [1:0]         axis;
    logic               has_nb;
    logic               on_boundary;
    logic [PATCH_W-1:0] patch;
    logic               has_pair;
  } face_flags_t;

endpackage

`default_nettype wire

// ===== sv/gfir_lane.sv =====
// ============================================================================
// gfir_lane
// Two-stage row-major index lane: t = v2*m1 + v1, then u = t*m0 + v0.
// ============================================================================
`default_nettype none

module gfir_lane
  import gfir_pkg::*;
(
  input  wire logic               clk,
  input  wire lane_ctrl_t         ctl,
  input  wire coord_vec_t         vec,
  input  wire logic [COORD_W-1:0] m1,
  input  wire logic [COORD_W-1:0] m0,
  output logic [ID_W-1:0]         idx
);

  logic [ROW_W-1:0]   t_r;
  logic [ROW_W-1:0]   t_nxt;
  logic [COORD_W-1:0] v0_r;
  logic [COORD_W-1:0] m0_r;
  logic [ID_W-1:0]    u_r;
  logic [ID_W-1:0]    u_nxt;
  logic [2*COORD_W-1:0] prod_a;
  logic [ROW_W+COORD_W-1:0] prod_b;

  // Row product: plane coordinate times row count plus row
  always_comb begin
    prod_a = vec[2] * m1;
    t_nxt  = ROW_W'(prod_a + (2*COORD_W)'(vec[1]));
  end

  // Final product: row index times row length plus column
  always_comb begin
    prod_b = t_r * m0_r;
    u_nxt  = ID_W'(prod_b + (ROW_W+COORD_W)'(v0_r));
  end

  // Advance the lane stages
  always_ff @(posedge clk) begin
    if (ctl.en_s2) begin
      t_r  <= t_nxt;
      v0_r <= vec[0];
      m0_r <= m0;
    end
    if (ctl.en_s3) begin
      u_r <= u_nxt;
    end
  end

  assign idx = u_r;

endmodule

`default_nettype wire

// ===== sv/grid_face_index_resolver.sv =====
// ============================================================================
// grid_face_index_resolver
// Resolves one structured-grid face per word: validity, global face id,
// owner and neighbour cells, boundary patch and periodic partner face.
// ============================================================================
// Usage: one face word is taken per clock while in_stall is low. Each
// accepted word passes four register stages in order: decode, row
// multiply, column multiply and the final offset add, with four parallel
// multiply lanes (face, owner, neighbour, partner). Stages fill bubbles
// independently, so the input keeps flowing into empty stages while a
// finished word waits at the output. The per-axis face counts are derived
// from the extents through registered row products, face counts and their
// sum after a configuration write; registers are to be written by the user
// only while no face word is in flight, which the block does not enforce.
`default_nettype none

module grid_face_index_resolver
  import gfir_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_W-1:0]   cfg_data,
  // Face word input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_face_axis,
  input  wire logic [COORD_W-1:0]   in_coord_x,
  input  wire logic [COORD_W-1:0]   in_coord_y,
  input  wire logic [COORD_W-1:0]   in_coord_z,
  // Result word output
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_bad_face,
  output logic [ID_W-1:0]           out_face_id,
  output logic [CELL_W-1:0]         out_owner_cell,
  output logic                      out_has_neighbour,
  output logic [CELL_W-1:0]         out_neighbour_cell,
  output logic                      out_on_boundary,
  output logic [PATCH_W-1:0]        out_patch_number,
  output logic                      out_has_pair,
  output logic [ID_W-1:0]           out_pair_face_id
);

  // --------------------------------------------------------------------------
  // Configuration registers and derived face counts
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] ext_x_r;
  logic [COORD_W-1:0] ext_y_r;
  logic [COORD_W-1:0] ext_z_r;
  logic [2:0]         per_r;
  logic [COORD_W-1:0] ext_nxt;
  logic [ROW_W-1:0]   xrow_r;   // (nx+1)*ny
  logic [ROW_W-1:0]   yrow_r;   // nx*(ny+1)
  logic [ID_W-1:0]    cnt_x_r;  // number of x faces
  logic [ID_W-1:0]    cnt_y_r;  // number of y faces
  logic [ID_W-1:0]    cnt_xy_r; // x faces plus y faces
  logic [2*COORD_W-1:0]     xrow_prod;
  logic [2*COORD_W-1:0]     yrow_prod;
  logic [ROW_W+COORD_W-1:0] cnt_x_prod;
  logic [ROW_W+COORD_W-1:0] cnt_y_prod;

  assign cfg_ready = 1'b1;

  // Clamp an extent write into 1..MAX_EXTENT
  always_comb begin
    if (cfg_data == '0) begin
      ext_nxt = COORD_W'(1);
    end else if (cfg_data > MAX_EXTENT) begin
      ext_nxt = MAX_EXTENT;
    end else begin
      ext_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_x_r <= COORD_W'(1);
      ext_y_r <= COORD_W'(1);
      ext_z_r <= COORD_W'(1);
      per_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXTENT_X: ext_x_r <= ext_nxt;
        REG_EXTENT_Y: ext_y_r <= ext_nxt;
        REG_EXTENT_Z: ext_z_r <= ext_nxt;
        REG_PERIODIC: per_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Derive face counts over two multiply stages and one add
  always_comb begin
    xrow_prod  = (ext_x_r + COORD_W'(1)) * ext_y_r;
    yrow_prod  = ext_x_r * (ext_y_r + COORD_W'(1));
    cnt_x_prod = xrow_r * ext_z_r;
    cnt_y_prod = yrow_r * ext_z_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xrow_r   <= ROW_W'(2);
      yrow_r   <= ROW_W'(2);
      cnt_x_r  <= ID_W'(2);
      cnt_y_r  <= ID_W'(2);
      cnt_xy_r <= ID_W'(4);
    end else begin
      xrow_r   <= ROW_W'(xrow_prod);
      yrow_r   <= ROW_W'(yrow_prod);
      cnt_x_r  <= ID_W'(cnt_x_prod);
      cnt_y_r  <= ID_W'(cnt_y_prod);
      cnt_xy_r <= cnt_x_r + cnt_y_r;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  logic v1_r;
  logic v2_r;
  logic v3_r;
  logic out_valid_r;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy_out;
  lane_ctrl_t lane_ctl;

  assign rdy_out = !out_valid_r || !out_stall;
  assign rdy3    = !v3_r || rdy_out;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign lane_ctl.en_s2 = rdy2;
  assign lane_ctl.en_s3 = rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy_out) out_valid_r <= v3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: decode the face and build lane coordinates
  // --------------------------------------------------------------------------
  coord_vec_t         n;
  coord_vec_t         c;
  coord_vec_t         own;
  coord_vec_t         nb;
  coord_vec_t         q;
  logic [COORD_W-1:0] p;
  logic [COORD_W-1:0] np;
  logic [COORD_W-1:0] m1_face;
  logic [COORD_W-1:0] m0_face;
  logic               wraps;
  logic               interior;
  face_flags_t        f_nxt;

  always_comb begin
    n = {ext_z_r, ext_y_r, ext_x_r};
    c = {in_coord_z, in_coord_y, in_coord_x};
    f_nxt = '0;
    f_nxt.ok   = 1'b1;
    f_nxt.axis = in_face_axis;
    p       = '0;
    np      = '0;
    wraps   = 1'b0;
    m1_face = ext_y_r;
    m0_face = ext_x_r;
    case (in_face_axis)
      AXIS_X: begin
        p = c[0]; np = n[0]; wraps = per_r[0];
        m0_face = ext_x_r + COORD_W'(1);
      end
      AXIS_Y: begin
        p = c[1]; np = n[1]; wraps = per_r[1];
        m1_face = ext_y_r + COORD_W'(1);
      end
      AXIS_Z: begin
        p = c[2]; np = n[2]; wraps = per_r[2];
      end
      default: f_nxt.ok = 1'b0;
    endcase

    // Range check: the normal coordinate may reach the extent
    for (int d = 0; d < 3; d++) begin
      if (2'(d) == in_face_axis) begin
        if (c[d] > n[d]) f_nxt.ok = 1'b0;
      end else if (c[d] >= n[d]) begin
        f_nxt.ok = 1'b0;
      end
    end

    interior = (p != '0) && (p < np);
    own = c;
    nb  = c;
    q   = c;
    for (int d = 0; d < 3; d++) begin
      if (2'(d) == in_face_axis) begin
        if (p != '0) own[d] = p - COORD_W'(1);
        if (!interior) nb[d] = (p == '0) ? np - COORD_W'(1) : '0;
        q[d] = (p == '0) ? np : '0;
      end
    end

    f_nxt.has_nb      = f_nxt.ok && (interior || wraps);
    f_nxt.on_boundary = f_nxt.ok && ((p == '0) || (p == np));
    f_nxt.has_pair    = f_nxt.on_boundary && wraps;
    if (f_nxt.on_boundary) begin
      f_nxt.patch = {in_face_axis, (p != '0)};
    end
  end

  face_flags_t        f1_r;
  face_flags_t        f2_r;
  face_flags_t        f3_r;
  coord_vec_t         s1_vec_r [N_LANES];
  logic [COORD_W-1:0] s1_m1_r  [N_LANES];
  logic [COORD_W-1:0] s1_m0_r  [N_LANES];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      f1_r <= f_nxt;
      s1_vec_r[LANE_FACE] <= c;
      s1_m1_r[LANE_FACE]  <= m1_face;
      s1_m0_r[LANE_FACE]  <= m0_face;
      s1_vec_r[LANE_OWN]  <= own;
      s1_m1_r[LANE_OWN]   <= ext_y_r;
      s1_m0_r[LANE_OWN]   <= ext_x_r;
      s1_vec_r[LANE_NB]   <= nb;
      s1_m1_r[LANE_NB]    <= ext_y_r;
      s1_m0_r[LANE_NB]    <= ext_x_r;
      s1_vec_r[LANE_PAIR] <= q;
      s1_m1_r[LANE_PAIR]  <= m1_face;
      s1_m0_r[LANE_PAIR]  <= m0_face;
    end
    if (rdy2) f2_r <= f1_r;
    if (rdy3) f3_r <= f2_r;
  end

  // --------------------------------------------------------------------------
  // Stages 2 and 3: row-major index lanes
  // --------------------------------------------------------------------------
  logic [ID_W-1:0] lane_idx [N_LANES];

  for (genvar g = 0; g < N_LANES; g++) begin : g_lane
    gfir_lane u_lane (
      .clk (clk),
      .ctl (lane_ctl),
      .vec (s1_vec_r[g]),
      .m1  (s1_m1_r[g]),
      .m0  (s1_m0_r[g]),
      .idx (lane_idx[g])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 4: add axis offset, zero unused fields, hold while stalled
  // --------------------------------------------------------------------------
  logic [ID_W-1:0]    base;
  logic               bad_r;
  logic [ID_W-1:0]    face_id_r;
  logic [CELL_W-1:0]  owner_r;
  logic               has_nb_r;
  logic [CELL_W-1:0]  nb_cell_r;
  logic               bound_r;
  logic [PATCH_W-1:0] patch_r;
  logic               has_pair_r;
  logic [ID_W-1:0]    pair_id_r;

  always_comb begin
    case (f3_r.axis)
      AXIS_Y:  base = cnt_x_r;
      AXIS_Z:  base = cnt_xy_r;
      default: base = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      bad_r      <= !f3_r.ok;
      face_id_r  <= f3_r.ok ? base + lane_idx[LANE_FACE] : '0;
      owner_r    <= f3_r.ok ? lane_idx[LANE_OWN][CELL_W-1:0] : '0;
      has_nb_r   <= f3_r.has_nb;
      nb_cell_r  <= f3_r.has_nb ? lane_idx[LANE_NB][CELL_W-1:0] : '0;
      bound_r    <= f3_r.on_boundary;
      patch_r    <= f3_r.patch;
      has_pair_r <= f3_r.has_pair;
      pair_id_r  <= f3_r.has_pair ? base + lane_idx[LANE_PAIR] : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bad_face       = bad_r;
  assign out_face_id        = face_id_r;
  assign out_owner_cell     = owner_r;
  assign out_has_neighbour  = has_nb_r;
  assign out_neighbour_cell = nb_cell_r;
  assign out_on_boundary    = bound_r;
  assign out_patch_number   = patch_r;
  assign out_has_pair       = has_pair_r;
  assign out_pair_face_id   = pair_id_r;

endmodule

`default_nettype wire

// ===== sv/grid_face_index_resolver_chk.sv =====
// ============================================================================
// grid_face_index_resolver_chk
// Port-level checks on result words of the face resolver, bound to the top.
// ============================================================================
`default_nettype none

module grid_face_index_resolver_chk
  import gfir_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_bad_face,
  input wire logic [ID_W-1:0]    out_face_id,
  input wire logic [CELL_W-1:0]  out_owner_cell,
  input wire logic               out_has_neighbour,
  input wire logic [CELL_W-1:0]  out_neighbour_cell,
  input wire logic               out_on_boundary,
  input wire logic [PATCH_W-1:0] out_patch_number,
  input wire logic               out_has_pair,
  input wire logic [ID_W-1:0]    out_pair_face_id
);

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_face_id))
    else $error("stalled result word changed");

  // Zero every field of a bad face
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_face |-> out_face_id == '0 && out_owner_cell == '0 &&
      !out_has_neighbour && !out_on_boundary && !out_has_pair &&
      out_patch_number == '0)
    else $error("bad face carries nonzero fields");

  // A partner face exists only on a boundary and with a neighbour
  a_pair_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_pair |-> out_on_boundary && out_has_neighbour)
    else $error("partner face off the boundary");

  // Patch is zero off the boundary and in range on it
  a_patch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_on_boundary && out_patch_number <= 3'd5) ||
      (!out_on_boundary && out_patch_number == '0))
    else $error("patch number inconsistent with boundary flag");

  // Absent neighbour and partner read as zero
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_has_neighbour || out_neighbour_cell == '0) &&
      (out_has_pair || out_pair_face_id == '0))
    else $error("absent neighbour or partner not zero");

endmodule

bind grid_face_index_resolver grid_face_index_resolver_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_bad_face       (out_bad_face),
  .out_face_id        (out_face_id),
  .out_owner_cell     (out_owner_cell),
  .out_has_neighbour  (out_has_neighbour),
  .out_neighbour_cell (out_neighbour_cell),
  .out_on_boundary    (out_on_boundary),
  .out_patch_number   (out_patch_number),
  .out_has_pair       (out_has_pair),
  .out_pair_face_id   (out_pair_face_id)
);

`default_nettype wire

// ===== test/grid_face_index_resolver_tb.sv =====
// ============================================================================
// grid_face_index_resolver_tb
// Self-checking bench for the structured-grid face resolver. A scoreboard
// class predicts each result word from the live register settings. It also
// compares the words leaving the block against that prediction in order.
// Directed faces cover the lattice corners, both boundaries of every axis,
// single-cell periodic grids and clamped extents. Random phases then sweep
// register settings with mostly well-formed faces and some invalid ones.
// ============================================================================
`default_nettype none

module grid_face_index_resolver_tb
  import gfir_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 5000;
  localparam int IDLE_PCT      = 10;
  localparam int RESET_ITEMS   = 60;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 120;
  localparam int CALM_PHASE    = 4;
  localparam int DRAIN_CYCLES  = 10;

  typedef struct packed {
    logic [1:0] axis;
    coord_vec_t coord;
  } face_word_t;

  typedef struct packed {
    logic               bad_face;
    logic [ID_W-1:0]    face_id;
    logic [CELL_W-1:0]  owner_cell;
    logic               has_neighbour;
    logic [CELL_W-1:0]  neighbour_cell;
    logic               on_boundary;
    logic [PATCH_W-1:0] patch_number;
    logic               has_pair;
    logic [ID_W-1:0]    pair_face_id;
  } face_result_t;

  // Predicts result words and checks them against the block, oldest first
  class face_scoreboard;
    logic [COORD_W-1:0] ext [3];
    logic [2:0]         wrap_mask;
    face_result_t       expected_q [$];
    int unsigned        mismatches;

    function new();
      ext       = '{11'd1, 11'd1, 11'd1};
      wrap_mask = 3'd0;
      mismatches = 0;
    endfunction

    function logic [COORD_W-1:0] clamp_extent(logic [COORD_W-1:0] v);
      if (v == '0) return 11'd1;
      if (v > MAX_EXTENT) return MAX_EXTENT;
      return v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
      case (idx)
        REG_EXTENT_X: ext[0] = clamp_extent(data);
        REG_EXTENT_Y: ext[1] = clamp_extent(data);
        REG_EXTENT_Z: ext[2] = clamp_extent(data);
        REG_PERIODIC: wrap_mask = data[2:0];
        default: ;
      endcase
    endfunction

    function longint unsigned cell_number(longint unsigned n [3], longint unsigned c [3]);
      return ((c[2] * n[1] + c[1]) * n[0] + c[0]) & 64'h3FFF_FFFF;
    endfunction

    // x faces first, then y, then z, each row-major with x fastest
    function longint unsigned face_number(longint unsigned n [3], int a,
                                          longint unsigned c [3]);
      longint unsigned x_count;
      longint unsigned y_count;
      longint unsigned id;
      x_count = (n[0] + 1) * n[1] * n[2];
      y_count = n[0] * (n[1] + 1) * n[2];
      if (a == int'(AXIS_X))
        id = (c[2] * n[1] + c[1]) * (n[0] + 1) + c[0];
      else if (a == int'(AXIS_Y))
        id = x_count + (c[2] * (n[1] + 1) + c[1]) * n[0] + c[0];
      else
        id = x_count + y_count + (c[2] * n[1] + c[1]) * n[0] + c[0];
      return id & 64'hFFFF_FFFF;
    endfunction

    function face_result_t resolve(face_word_t f);
      face_result_t    r;
      longint unsigned n [3];
      longint unsigned c [3];
      longint unsigned own [3];
      longint unsigned nb [3];
      longint unsigned q [3];
      longint unsigned p;
      int              a;
      bit              ok;
      bit              wraps;
      r = '0;
      a = int'(f.axis);
      ok = (f.axis != AXIS_NONE);
      for (int d = 0; d < 3; d++) begin
        n[d] = ext[d];
        c[d] = f.coord[d];
        if (d == a) begin
          if (c[d] > n[d]) ok = 0;
        end else if (c[d] >= n[d]) begin
          ok = 0;
        end
      end
      if (!ok) begin
        r.bad_face = 1'b1;
        return r;
      end
      r.face_id = face_number(n, a, c);
      p = c[a];
      wraps = wrap_mask[a];
      own = c;
      nb  = c;
      q   = c;
      // owner sits below the face except on the low boundary
      if (p > 0) own[a] = p - 1;
      r.owner_cell = cell_number(n, own);
      if (p > 0 && p < n[a]) begin
        r.has_neighbour  = 1'b1;
        r.neighbour_cell = cell_number(n, nb);
      end else begin
        r.on_boundary  = 1'b1;
        r.patch_number = PATCH_W'(2 * a + ((p == 0) ? 0 : 1));
        if (wraps) begin
          // wrap to the cell and face at the far end of the axis
          nb = own;
          nb[a] = (p == 0) ? n[a] - 1 : 0;
          q[a]  = (p == 0) ? n[a] : 0;
          r.has_neighbour  = 1'b1;
          r.neighbour_cell = cell_number(n, nb);
          r.has_pair       = 1'b1;
          r.pair_face_id   = face_number(n, a, q);
        end
      end
      return r;
    endfunction

    function void note_face(face_word_t f);
      expected_q.insert(expected_q.size(), resolve(f));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string what, longint unsigned want, longint unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endfunction

    function void check_result(face_result_t got);
      face_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result word", 0, got.face_id);
        return;
      end
      want = expected_q.pop_front();
      if (got.bad_face !== want.bad_face)
        report("bad_face", want.bad_face, got.bad_face);
      if (got.face_id !== want.face_id)
        report("face_id", want.face_id, got.face_id);
      if (got.owner_cell !== want.owner_cell)
        report("owner_cell", want.owner_cell, got.owner_cell);
      if (got.has_neighbour !== want.has_neighbour)
        report("has_neighbour", want.has_neighbour, got.has_neighbour);
      if (got.neighbour_cell !== want.neighbour_cell)
        report("neighbour_cell", want.neighbour_cell, got.neighbour_cell);
      if (got.on_boundary !== want.on_boundary)
        report("on_boundary", want.on_boundary, got.on_boundary);
      if (got.patch_number !== want.patch_number)
        report("patch_number", want.patch_number, got.patch_number);
      if (got.has_pair !== want.has_pair)
        report("has_pair", want.has_pair, got.has_pair);
      if (got.pair_face_id !== want.pair_face_id)
        report("pair_face_id", want.pair_face_id, got.pair_face_id);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_face_axis;
  logic [COORD_W-1:0]   in_coord_x;
  logic [COORD_W-1:0]   in_coord_y;
  logic [COORD_W-1:0]   in_coord_z;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_bad_face;
  logic [ID_W-1:0]      out_face_id;
  logic [CELL_W-1:0]    out_owner_cell;
  logic                 out_has_neighbour;
  logic [CELL_W-1:0]    out_neighbour_cell;
  logic                 out_on_boundary;
  logic [PATCH_W-1:0]   out_patch_number;
  logic                 out_has_pair;
  logic [ID_W-1:0]      out_pair_face_id;

  face_scoreboard sb;
  bit             calm;
  int unsigned    quiet_cycles = 0;

  grid_face_index_resolver dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_face_axis      (in_face_axis),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bad_face      (out_bad_face),
    .out_face_id       (out_face_id),
    .out_owner_cell    (out_owner_cell),
    .out_has_neighbour (out_has_neighbour),
    .out_neighbour_cell(out_neighbour_cell),
    .out_on_boundary   (out_on_boundary),
    .out_patch_number  (out_patch_number),
    .out_has_pair      (out_has_pair),
    .out_pair_face_id  (out_pair_face_id)
  );

  always #1 clk = ~clk;

  // Stall the result side at random, except during the calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Check every result word as it is taken
  always @(posedge clk) begin
    face_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.bad_face       = out_bad_face;
      got.face_id        = out_face_id;
      got.owner_cell     = out_owner_cell;
      got.has_neighbour  = out_has_neighbour;
      got.neighbour_cell = out_neighbour_cell;
      got.on_boundary    = out_on_boundary;
      got.patch_number   = out_patch_number;
      got.has_pair       = out_has_pair;
      got.pair_face_id   = out_pair_face_id;
      sb.check_result(got);
    end
  end

  // Abort when no handshake of any kind completes for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("grid_face_index_resolver verification failed");
      $finish;
    end
  end

  // Offer one face word, hold it until taken; entered and left at a falling edge
  task automatic push_face(input face_word_t f);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_face_axis <= f.axis;
    in_coord_x   <= f.coord[0];
    in_coord_y   <= f.coord[1];
    in_coord_z   <= f.coord[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_face(f);
    @(negedge clk);
  endtask

  // Write one register; the caller drops cfg_valid after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Drain the pipeline, rewrite every register, let face counts settle
  task automatic reconfigure(input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                             input logic [COORD_W-1:0] ez, input logic [2:0] mask);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
    write_reg(REG_EXTENT_X, ex);
    write_reg(REG_EXTENT_Y, ey);
    write_reg(REG_EXTENT_Z, ez);
    write_reg(REG_PERIODIC, {8'd0, mask});
    cfg_valid <= 1'b0;
    repeat (5) @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] random_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return COORD_W'($urandom_range(1, 16));
    if (r < 85) return COORD_W'($urandom_range(17, 1024));
    if (r < 90) return '0;
    if (r < 95) return MAX_EXTENT;
    return COORD_W'($urandom_range(1025, 2047));
  endfunction

  // Mostly faces inside the lattice, boundaries weighted; the rest is noise
  function automatic face_word_t random_face();
    face_word_t f;
    int         n [3];
    int         a;
    int         r;
    for (int d = 0; d < 3; d++) n[d] = int'(sb.ext[d]);
    if ($urandom_range(0, 99) < 85) begin
      a = $urandom_range(0, 2);
      f.axis = 2'(a);
      for (int d = 0; d < 3; d++) begin
        r = $urandom_range(0, 9);
        if (d != a) f.coord[d] = COORD_W'($urandom_range(0, n[d] - 1));
        else if (r < 2) f.coord[d] = '0;
        else if (r < 4) f.coord[d] = COORD_W'(n[d]);
        else f.coord[d] = COORD_W'($urandom_range(0, n[d]));
      end
    end else begin
      f.axis = 2'($urandom_range(0, 3));
      for (int d = 0; d < 3; d++) begin
        if ($urandom_range(0, 1) == 0) f.coord[d] = COORD_W'($urandom_range(0, 2047));
        else f.coord[d] = COORD_W'($urandom_range(0, n[d] + 1));
      end
    end
    return f;
  endfunction

  // Both boundaries and a middle face per axis, then each kind of invalid face
  task automatic run_directed();
    face_word_t f;
    int         n [3];
    for (int d = 0; d < 3; d++) n[d] = int'(sb.ext[d]);
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        f.axis = 2'(a);
        for (int d = 0; d < 3; d++) f.coord[d] = COORD_W'(n[d] - 1);
        f.coord[a] = (k == 0) ? '0 : (k == 1) ? COORD_W'(n[a]) : COORD_W'(n[a] / 2);
        push_face(f);
      end
    end
    f.axis = AXIS_NONE;
    f.coord = '0;
    push_face(f);
    f.axis = AXIS_X;
    f.coord[0] = COORD_W'(n[0] + 1);
    push_face(f);
    f.axis = AXIS_Y;
    f.coord = '0;
    f.coord[0] = COORD_W'(n[0]);
    push_face(f);
    f.axis = AXIS_Z;
    f.coord = '1;
    push_face(f);
  endtask

  initial begin
    sb           = new();
    calm         = 1'b0;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_face_axis = '0;
    in_coord_x   = '0;
    in_coord_y   = '0;
    in_coord_z   = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: one cell, nothing periodic
    for (int i = 0; i < RESET_ITEMS; i++) push_face(random_face());

    // Zero extents held as one cell, every axis periodic
    reconfigure('0, '0, '0, 3'b111);
    run_directed();

    // Largest lattice, oversize x extent clamped
    reconfigure(11'd2047, MAX_EXTENT, MAX_EXTENT, 3'b111);
    run_directed();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      reconfigure(random_extent(), random_extent(), random_extent(),
                  3'($urandom_range(0, 7)));
      calm = (ph == CALM_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++) push_face(random_face());
      calm = 1'b0;
    end
    in_valid <= 1'b0;

    // Drain, then give the pipeline time to show any stray word
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("grid_face_index_resolver verification clean");
    end else begin
      $display("grid_face_index_resolver verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== grid_face_index_resolver.f =====
sv/gfir_pkg.sv
sv/gfir_lane.sv
sv/grid_face_index_resolver.sv
sv/grid_face_index_resolver_chk.sv
test/grid_face_index_resolver_tb.sv
